// File: rtl/lpmf_pkg.sv
// shared types and codes for the length-prefixed message fifo
package lpmf_pkg;

	// operation codes of a request
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// result status codes
	localparam logic [2:0] ST_STAGED    = 3'd0;
	localparam logic [2:0] ST_COMMITTED = 3'd1;
	localparam logic [2:0] ST_REJECTED  = 3'd2;
	localparam logic [2:0] ST_READ      = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	// request payload
	typedef struct packed {
		logic       operation;
		logic [7:0] data_in;
		logic       last_in;
	} msg_in_t;

	// result payload
	typedef struct packed {
		logic [7:0]  data_out;
		logic        end_of_message;
		logic [2:0]  status;
		logic [10:0] free_bytes;
	} msg_out_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
		logic wr_len;
		logic rd_len;
		logic rd_data;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic op;
		logic commit;
		logic reading;
		logic empty;
		logic len_zero;
	} dp_stat_t;

endpackage

// File: rtl/lpmf_ram.sv
// generic single-port-write ram with registered read
module lpmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/lpmf_ctrl.sv
// controller state machine for the length-prefixed message fifo
module lpmf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  lpmf_pkg::dp_stat_t stat,
	output logic               busy,
	output lpmf_pkg::dp_cmd_t  cmd
);

	import lpmf_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_EXEC    = 3'd1;
	localparam logic [2:0] S_WR_LEN  = 3'd2;
	localparam logic [2:0] S_RD_LEN  = 3'd3;
	localparam logic [2:0] S_RD_DATA = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_n;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_n = S_EXEC;
			end
			S_EXEC: begin
				if (stat.op == OP_WRITE) begin
					state_n = stat.commit ? S_WR_LEN : S_IDLE;
				end else if (stat.reading) begin
					state_n = S_RD_DATA;
				end else if (stat.empty) begin
					state_n = S_IDLE;
				end else begin
					state_n = S_RD_LEN;
				end
			end
			S_WR_LEN:  state_n = S_IDLE;
			S_RD_LEN:  state_n = stat.len_zero ? S_IDLE : S_RD_DATA;
			S_RD_DATA: state_n = S_IDLE;
			default:   state_n = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// command decode
	always_comb begin
		busy        = (state_q != S_IDLE);
		cmd.load    = (state_q == S_IDLE) && start;
		cmd.exec    = (state_q == S_EXEC);
		cmd.wr_len  = (state_q == S_WR_LEN);
		cmd.rd_len  = (state_q == S_RD_LEN);
		cmd.rd_data = (state_q == S_RD_DATA);
	end

endmodule

// File: rtl/lpmf_dp.sv
// datapath for the length-prefixed message fifo: pointers, counts and byte store
module lpmf_dp #(
	parameter int DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lpmf_pkg::msg_in_t  request,
	input  lpmf_pkg::dp_cmd_t  cmd,
	output lpmf_pkg::dp_stat_t stat,
	output logic               done,
	output lpmf_pkg::msg_out_t result
);

	import lpmf_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int SW = ((FW > 9) ? FW : 9) + 1;
	localparam int AW = ((PW > 9) ? PW : 9) + 1;

	// latched request
	logic       op_q;
	logic [7:0] data_q;
	logic       last_q;

	// store state
	logic [PW-1:0] wp_q, wp_n;
	logic [PW-1:0] rp_q, rp_n;
	logic [FW-1:0] free_q, free_n;
	logic [8:0]    sl_q, sl_n;
	logic          ovf_q, ovf_n;
	logic [7:0]    rem_q, rem_n;
	logic          reading_q, reading_n;
	logic [7:0]    mlen_q, mlen_n;

	// result register
	msg_out_t result_q, res_n;
	logic     done_q, done_n;

	// ram ports
	logic          we;
	logic [PW-1:0] waddr;
	logic [7:0]    wdata;
	logic [7:0]    rdata;

	// helper terms
	logic [SW-1:0]    sl_ext, free_ext, free_sum, free_cap;
	logic [7:0]       add_len;
	logic             store_ok, ovf_next, commit;
	logic [8:0]       sl_inc;
	logic [AW-1:0]    wsum, wsum_wrap;
	logic [PW-1:0]    wp_off;
	logic [PW-1:0]    rp_inc;
	logic [FW+10:0]   free_wide;

	lpmf_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rp_q),
		.rdata (rdata)
	);

	// staging room check and commit decision
	always_comb begin
		sl_ext   = SW'(sl_q);
		free_ext = SW'(free_q);
		store_ok = !ovf_q && (sl_q < 9'd255) && ((sl_ext + SW'(1)) < free_ext);
		ovf_next = ovf_q | ~store_ok;
		commit   = last_q & ~ovf_next;
		sl_inc   = (sl_q < 9'd256) ? (sl_q + 9'd1) : sl_q;
	end

	// ring offset past the write pointer, and read pointer step
	always_comb begin
		wsum      = AW'(wp_q) + AW'(sl_q) + AW'(1);
		wsum_wrap = (wsum >= AW'(DEPTH)) ? (wsum - AW'(DEPTH)) : wsum;
		wp_off    = wsum_wrap[PW-1:0];
		rp_inc    = (rp_q == PW'(DEPTH - 1)) ? '0 : (rp_q + PW'(1));
	end

	// space returned at the end of a message, capped at depth
	always_comb begin
		add_len  = cmd.rd_len ? 8'd0 : mlen_q;
		free_sum = free_ext + SW'(add_len) + SW'(1);
		free_cap = (free_sum > SW'(DEPTH)) ? SW'(DEPTH) : free_sum;
	end

	// item sequencing
	always_comb begin
		wp_n      = wp_q;
		rp_n      = rp_q;
		free_n    = free_q;
		sl_n      = sl_q;
		ovf_n     = ovf_q;
		rem_n     = rem_q;
		reading_n = reading_q;
		mlen_n    = mlen_q;
		we        = 1'b0;
		waddr     = wp_off;
		wdata     = data_q;
		done_n    = 1'b0;
		res_n.data_out       = 8'd0;
		res_n.end_of_message = 1'b0;
		res_n.status         = ST_STAGED;

		if (cmd.exec && op_q == OP_WRITE) begin
			// stage one byte
			we    = store_ok;
			sl_n  = sl_inc;
			ovf_n = ovf_next;
			if (!last_q) begin
				done_n = 1'b1;
			end else if (!commit) begin
				sl_n         = 9'd0;
				ovf_n        = 1'b0;
				res_n.status = ST_REJECTED;
				done_n       = 1'b1;
			end
		end else if (cmd.wr_len) begin
			// length byte and commit
			we           = 1'b1;
			waddr        = wp_q;
			wdata        = sl_q[7:0];
			wp_n         = wp_off;
			free_n       = FW'(free_ext - (sl_ext + SW'(1)));
			sl_n         = 9'd0;
			ovf_n        = 1'b0;
			res_n.status = ST_COMMITTED;
			done_n       = 1'b1;
		end else if (cmd.exec && op_q == OP_READ) begin
			// start a read: report empty, or fetch data or length byte
			if (reading_q) begin
				rp_n = rp_inc;
			end else if (stat.empty) begin
				res_n.status = ST_EMPTY;
				done_n       = 1'b1;
			end else begin
				rp_n = rp_inc;
			end
		end else if (cmd.rd_len) begin
			// length byte arrived
			mlen_n    = rdata;
			rem_n     = rdata;
			reading_n = 1'b1;
			if (rdata != 8'd0) begin
				rp_n = rp_inc;
			end else begin
				reading_n            = 1'b0;
				free_n               = FW'(free_cap);
				mlen_n               = 8'd0;
				res_n.status         = ST_READ;
				res_n.end_of_message = 1'b1;
				done_n               = 1'b1;
			end
		end else if (cmd.rd_data) begin
			// data byte arrived
			rem_n          = rem_q - 8'd1;
			res_n.data_out = rdata;
			res_n.status   = ST_READ;
			done_n         = 1'b1;
			if (rem_q == 8'd1) begin
				reading_n            = 1'b0;
				free_n               = FW'(free_cap);
				mlen_n               = 8'd0;
				res_n.end_of_message = 1'b1;
			end
		end

		free_wide        = (FW + 11)'(free_n);
		res_n.free_bytes = free_wide[10:0];
	end

	// status towards the controller
	always_comb begin
		stat.op       = op_q;
		stat.commit   = commit;
		stat.reading  = reading_q;
		stat.empty    = (free_q >= FW'(DEPTH));
		stat.len_zero = (rdata == 8'd0);
	end

	// request latch and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= request.operation;
			data_q <= request.data_in;
			last_q <= request.last_in;
		end
		if (done_n) begin
			result_q <= res_n;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			free_q    <= FW'(DEPTH);
			sl_q      <= 9'd0;
			ovf_q     <= 1'b0;
			rem_q     <= 8'd0;
			reading_q <= 1'b0;
			mlen_q    <= 8'd0;
			done_q    <= 1'b0;
		end else begin
			wp_q      <= wp_n;
			rp_q      <= rp_n;
			free_q    <= free_n;
			sl_q      <= sl_n;
			ovf_q     <= ovf_n;
			rem_q     <= rem_n;
			reading_q <= reading_n;
			mlen_q    <= mlen_n;
			done_q    <= done_n;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: rtl/length_prefixed_message_fifo.sv
// length-prefixed message fifo: top level joining controller and datapath
// a staged or rejected byte or an empty read ends in the exec state; a committing last
// byte then writes the length byte; a read inside a message fetches one data byte; the
// first message byte fetches the length byte, then the data, through the one ram port
// a new request is taken once busy falls, which is as the previous result shows
// reset clears pointers and counts at once, no clearing pass; done is a one-cycle pulse
module length_prefixed_message_fifo #(
	parameter int DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  lpmf_pkg::msg_in_t  request,
	output logic               busy,
	output logic               done,
	output lpmf_pkg::msg_out_t result
);

	import lpmf_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	lpmf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	lpmf_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.done    (done),
		.result  (result)
	);

endmodule

// File: test/length_prefixed_message_fifo_tb.sv
// testbench for the length-prefixed message fifo: directed and random requests against a predictor
module length_prefixed_message_fifo_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpmf_pkg::*;

	localparam int STORE_DEPTH = 1024;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_REPORTS = 10;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	msg_in_t  request = '0;
	logic     busy;
	logic     done;
	msg_out_t result;

	// predictor state
	logic [7:0] ring_mem [STORE_DEPTH];
	int rd_ptr = 0;
	int wr_ptr = 0;
	int free_cnt = STORE_DEPTH;
	int stage_len = 0;
	bit stage_ovf = 1'b0;
	int rd_left = 0;
	bit in_msg = 1'b0;
	int cur_len = 0;

	// results still owed by the block, oldest first
	msg_out_t expected_results [$];

	bit idle_on = 1'b1;
	int requests_sent = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int status_count [5];

	length_prefixed_message_fifo #(.DEPTH(STORE_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #10 clk = ~clk;

	// expected result of one request, advancing the predictor state
	function automatic msg_out_t fifo_predict(input msg_in_t req);
		msg_out_t res;
		res = '0;
		if (req.operation == OP_WRITE) begin
			// stage the byte at its offset past the write pointer if it still fits
			if (!stage_ovf && stage_len < 255 && stage_len + 1 < free_cnt) begin
				ring_mem[(wr_ptr + stage_len + 1) % STORE_DEPTH] = req.data_in;
			end else begin
				stage_ovf = 1'b1;
			end
			if (stage_len < 256)
				stage_len++;
			if (!req.last_in) begin
				res.status = ST_STAGED;
			end else begin
				if (!stage_ovf) begin
					ring_mem[wr_ptr] = stage_len[7:0];
					wr_ptr = (wr_ptr + stage_len + 1) % STORE_DEPTH;
					free_cnt -= stage_len + 1;
					res.status = ST_COMMITTED;
				end else begin
					res.status = ST_REJECTED;
				end
				stage_len = 0;
				stage_ovf = 1'b0;
			end
		end else if (!in_msg && free_cnt >= STORE_DEPTH) begin
			res.status = ST_EMPTY;
		end else begin
			// fetch the length byte when a new message starts
			if (!in_msg) begin
				cur_len = int'(ring_mem[rd_ptr]);
				rd_ptr = (rd_ptr + 1) % STORE_DEPTH;
				rd_left = cur_len;
				in_msg = 1'b1;
			end
			if (rd_left > 0) begin
				res.data_out = ring_mem[rd_ptr];
				rd_ptr = (rd_ptr + 1) % STORE_DEPTH;
				rd_left--;
			end
			// last byte gives back the whole message space
			if (rd_left == 0) begin
				res.end_of_message = 1'b1;
				in_msg = 1'b0;
				free_cnt += cur_len + 1;
				if (free_cnt > STORE_DEPTH)
					free_cnt = STORE_DEPTH;
				cur_len = 0;
			end
			res.status = ST_READ;
		end
		res.free_bytes = free_cnt[10:0];
		status_count[res.status]++;
		return res;
	endfunction

	// drive one request and wait until the block takes it
	task automatic send_request(input logic op, input logic [7:0] data_val,
			input logic last_flag, output msg_out_t predicted);
		msg_in_t req;
		int gap;
		req.operation = op;
		req.data_in = data_val;
		req.last_in = last_flag;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		predicted = fifo_predict(req);
		expected_results.push_back(predicted);
		requests_sent++;
	endtask

	// one message of random bytes, with reads mixed in at the given percentage
	task automatic write_message(input int len, input int read_pct);
		msg_out_t r;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < read_pct)
				send_request(OP_READ, 8'($urandom), 1'($urandom), r);
			send_request(OP_WRITE, 8'($urandom), i == len - 1, r);
		end
	endtask

	// read until the oldest message ends or the store reports empty
	task automatic read_message();
		msg_out_t r;
		do begin
			send_request(OP_READ, 8'($urandom), 1'($urandom), r);
		end while (r.status == ST_READ && !r.end_of_message);
	endtask

	// hold the sender off until every result is in
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// empty store, single bytes at both data extremes, a read between staged bytes
	task automatic test_basic_messages();
		msg_out_t r;
		idle_on = 1'b1;
		send_request(OP_READ, 8'hff, 1'b1, r);
		send_request(OP_READ, 8'h00, 1'b0, r);
		send_request(OP_WRITE, 8'h00, 1'b1, r);
		send_request(OP_WRITE, 8'hff, 1'b1, r);
		send_request(OP_WRITE, 8'h5a, 1'b0, r);
		send_request(OP_READ, 8'h00, 1'b0, r);
		send_request(OP_WRITE, 8'ha5, 1'b0, r);
		send_request(OP_WRITE, 8'h3c, 1'b1, r);
		read_message();
		read_message();
		send_request(OP_READ, 8'hff, 1'b0, r);
		wait_drained();
	endtask

	// longest message commits, one byte longer is rejected
	task automatic test_length_limits();
		msg_out_t r;
		idle_on = 1'b1;
		write_message(255, 0);
		idle_on = 1'b0;
		write_message(256, 0);
		idle_on = 1'b1;
		read_message();
		send_request(OP_READ, 8'($urandom), 1'($urandom), r);
		wait_drained();
	endtask

	// fill to the last byte, reject at full, reject after space comes back mid-message
	task automatic test_full_store();
		msg_out_t r;
		int room;
		int len;
		idle_on = 1'b1;
		while (free_cnt > 1) begin
			room = (free_cnt - 1 > 255) ? 255 : free_cnt - 1;
			len = $urandom_range(0, 1) ? room : $urandom_range(1, room);
			write_message(len, 0);
		end
		write_message(1, 0);
		send_request(OP_WRITE, 8'($urandom), 1'b0, r);
		send_request(OP_WRITE, 8'($urandom), 1'b0, r);
		read_message();
		send_request(OP_WRITE, 8'($urandom), 1'b1, r);
		while (free_cnt < STORE_DEPTH || in_msg) read_message();
		send_request(OP_READ, 8'($urandom), 1'($urandom), r);
		wait_drained();
	endtask

	// mixed traffic: messages of random length and content against read bursts
	task automatic test_random_traffic(input int target);
		msg_out_t r;
		int first_sent;
		int kind;
		int len;
		bit paused;
		first_sent = requests_sent;
		paused = 1'b0;
		while (requests_sent - first_sent < target) begin
			idle_on = ($urandom_range(0, 3) != 0);
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				len = $urandom_range(0, 99);
				if (len < 75)
					len = $urandom_range(1, 6);
				else if (len < 95)
					len = $urandom_range(7, 32);
				else if (len < 99)
					len = $urandom_range(33, 255);
				else
					len = $urandom_range(256, 264);
				write_message(len, $urandom_range(0, 30));
			end else if (kind < 95) begin
				repeat ($urandom_range(1, 16))
					send_request(OP_READ, 8'($urandom), 1'($urandom), r);
			end else begin
				read_message();
			end
			// one full pause in the middle of the traffic
			if (!paused && requests_sent - first_sent > target / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
		wait_drained();
	endtask

	function automatic void check_field(input string name, input logic [10:0] want,
			input logic [10:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("mismatch on %s: expected %0h, got %0h at %0t", name, want, got, $time);
		end
	endfunction

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		msg_out_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("result with no request outstanding at %0t", $time);
			end else begin
				want = expected_results.pop_front();
				check_field("data_out", 11'(want.data_out), 11'(result.data_out));
				check_field("end_of_message", 11'(want.end_of_message),
					11'(result.end_of_message));
				check_field("status", 11'(want.status), 11'(result.status));
				check_field("free_bytes", want.free_bytes, result.free_bytes);
				results_checked++;
			end
		end
	end

	// runaway guard
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timed out with %0d results outstanding", expected_results.size());
		$display("[length_prefixed_message_fifo] ERROR");
		$finish;
	end

	initial begin
		foreach (ring_mem[i]) ring_mem[i] = 8'h00;
		foreach (status_count[i]) status_count[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_messages();
		test_length_limits();
		test_full_store();
		test_random_traffic(1500);

		// let any stray result show
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0)
			mismatch_count++;

		$display("%0d requests, %0d results checked, %0d mismatches", requests_sent,
			results_checked, mismatch_count);
		$display("staged %0d, committed %0d, rejected %0d, read %0d, empty %0d",
			status_count[ST_STAGED], status_count[ST_COMMITTED], status_count[ST_REJECTED],
			status_count[ST_READ], status_count[ST_EMPTY]);
		if (mismatch_count == 0) begin
			$display("[length_prefixed_message_fifo] OK");
		end else begin
			$display("[length_prefixed_message_fifo] ERROR");
		end
		$finish;
	end

endmodule
